// ===== src/owrse_pkg.sv =====
// Shared types and codes for the 1-Wire Search ROM branch engine.
`default_nettype none

package owrse_pkg;

    localparam int POS_W     = 7;   // bit positions 0..65
    localparam int FOUND_W   = 64;  // width of the reported ROM field
    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 3;
    localparam int S_TDATA_W = 8;   // presence, true_bit, complement_bit, zero fill
    localparam int M_TDATA_W = 72;  // write_bit, found_rom, zero fill

    typedef enum logic [ACTION_W-1:0] {
        ACT_NEW_SEARCH = 2'd0,
        ACT_BEGIN_PASS = 2'd1,
        ACT_BIT_PAIR   = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_BIT         = 3'd0,
        ST_STARTED     = 3'd1,
        ST_FINISHED    = 3'd2,
        ST_NO_PRESENCE = 3'd3,
        ST_FOUND       = 3'd4,
        ST_NO_RESPONSE = 3'd5,
        ST_IGNORED     = 3'd6
    } status_t;

    typedef struct packed {
        logic [POS_W-1:0] last_fork_pos;
        logic [POS_W-1:0] new_fork_pos;
        logic [POS_W-1:0] bit_position;
        logic             pass_active;
    } search_ctrl_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                presence;
        logic                true_bit;
        logic                complement_bit;
    } search_item_t;

    typedef struct packed {
        status_t             status;
        logic                write_bit;
        logic [FOUND_W-1:0]  found_rom;
    } search_result_t;

endpackage

`default_nettype wire

// ===== src/owrse_decide.sv =====
// Combinational branch decision and next-state logic for one search item.
`default_nettype none

module owrse_decide
    import owrse_pkg::*;
#(
    parameter int ROM_BITS = 64
) (
    input  wire search_item_t        item,
    input  wire search_ctrl_t        ctrl,
    input  wire [ROM_BITS-1:0]       prev_rom,
    input  wire [ROM_BITS-1:0]       cur_rom,
    output search_ctrl_t             ctrl_next,
    output logic [ROM_BITS-1:0]      prev_rom_next,
    output logic [ROM_BITS-1:0]      cur_rom_next,
    output search_result_t           result
);

    localparam int IDX_W = (ROM_BITS > 1) ? $clog2(ROM_BITS) : 1;
    localparam logic [POS_W-1:0] FORK_INIT = POS_W'(ROM_BITS + 1);
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(ROM_BITS);
    localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1);

    logic [POS_W-1:0]    pos;
    logic [POS_W-1:0]    pos_m1;
    logic [IDX_W-1:0]    idx;
    logic                pos_ok;
    logic                dir;
    logic                fork_here;
    logic [POS_W-1:0]    fork_next;
    logic [ROM_BITS-1:0] rom_set;

    assign pos    = ctrl.bit_position;
    assign pos_m1 = pos - POS_ONE;
    assign idx    = pos_m1[IDX_W-1:0];
    assign pos_ok = ctrl.pass_active && (pos >= POS_ONE) && (pos <= LAST_POS);

    // direction for a bit pair; zero-branch taken at a discrepancy marks a fork
    always_comb begin
        dir       = 1'b0;
        fork_here = 1'b0;
        priority if (item.true_bit) begin
            dir = 1'b1;
        end else if (item.complement_bit) begin
            dir = 1'b0;
        end else if (pos < ctrl.last_fork_pos) begin
            dir       = prev_rom[idx];
            fork_here = !prev_rom[idx];
        end else if (pos == ctrl.last_fork_pos) begin
            dir = 1'b1;
        end else begin
            dir       = 1'b0;
            fork_here = 1'b1;
        end
    end

    assign fork_next = fork_here ? pos : ctrl.new_fork_pos;
    assign rom_set   = cur_rom | ({{(ROM_BITS-1){1'b0}}, dir} << idx);

    always_comb begin
        ctrl_next        = ctrl;
        prev_rom_next    = prev_rom;
        cur_rom_next     = cur_rom;
        result.status    = ST_IGNORED;
        result.write_bit = 1'b0;
        result.found_rom = '0;
        unique case (item.action)
            ACT_NEW_SEARCH: begin
                ctrl_next.last_fork_pos = FORK_INIT;
                ctrl_next.new_fork_pos  = '0;
                ctrl_next.bit_position  = '0;
                ctrl_next.pass_active   = 1'b0;
                prev_rom_next           = '0;
                cur_rom_next            = '0;
            end
            ACT_BEGIN_PASS: begin
                ctrl_next.pass_active = 1'b0;
                priority if (ctrl.last_fork_pos == '0) begin
                    result.status = ST_FINISHED;
                end else if (!item.presence) begin
                    result.status = ST_NO_PRESENCE;
                end else begin
                    ctrl_next.pass_active  = 1'b1;
                    ctrl_next.bit_position = POS_ONE;
                    ctrl_next.new_fork_pos = '0;
                    cur_rom_next           = '0;
                    result.status          = ST_STARTED;
                end
            end
            ACT_BIT_PAIR: begin
                if (pos_ok) begin
                    priority if (item.true_bit && item.complement_bit) begin
                        ctrl_next.pass_active = 1'b0;
                        result.status         = ST_NO_RESPONSE;
                    end else if (pos == LAST_POS) begin
                        ctrl_next.new_fork_pos  = fork_next;
                        ctrl_next.last_fork_pos = fork_next;
                        ctrl_next.pass_active   = 1'b0;
                        cur_rom_next            = rom_set;
                        prev_rom_next           = rom_set;
                        result.status           = ST_FOUND;
                        result.write_bit        = dir;
                        result.found_rom        = FOUND_W'(rom_set);
                    end else begin
                        ctrl_next.new_fork_pos = fork_next;
                        ctrl_next.bit_position = pos + POS_ONE;
                        cur_rom_next           = rom_set;
                        result.status          = ST_BIT;
                        result.write_bit       = dir;
                    end
                end
            end
            default: begin
                result.status = ST_IGNORED;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/onewire_rom_search_engine_unit.sv =====
// Top level of the 1-Wire Search ROM branch engine: input stage, state and result stage.
// An item passes through the input register and then the result register; search state
// updates as it enters the result register. One item per cycle unless m_tready stalls.
// Reset (aresetn low, synchronous): both stages empty, search state cleared to zero,
// so a begin-pass before any new-search reports search finished.
// A stalled result register holds its item while the input stage still takes one more.
`default_nettype none

module onewire_rom_search_engine_unit
    import owrse_pkg::*;
#(
    parameter int ROM_BITS = 64
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    // input channel
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire [S_TDATA_W-1:0]   s_tdata,   // [0] presence, [1] true_bit, [2] complement_bit
    input  wire [ACTION_W-1:0]    s_tuser,   // [1:0] action
    // result channel
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [0] write_bit, [64:1] found_rom
    output logic [STATUS_W-1:0]   m_tuser    // [2:0] status
);

    // input stage
    logic                in_valid_reg;
    search_item_t        in_item_reg;

    // search state
    search_ctrl_t        ctrl_reg;
    search_ctrl_t        ctrl_next;
    logic [ROM_BITS-1:0] prev_rom_reg;
    logic [ROM_BITS-1:0] prev_rom_next;
    logic [ROM_BITS-1:0] cur_rom_reg;
    logic [ROM_BITS-1:0] cur_rom_next;

    // result stage
    logic                out_valid_reg;
    search_result_t      out_reg;
    search_result_t      result;

    logic                advance;
    logic                s_xfer;

    // item moves on when the result register is empty or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    owrse_decide #(
        .ROM_BITS (ROM_BITS)
    ) u_decide (
        .item          (in_item_reg),
        .ctrl          (ctrl_reg),
        .prev_rom      (prev_rom_reg),
        .cur_rom       (cur_rom_reg),
        .ctrl_next     (ctrl_next),
        .prev_rom_next (prev_rom_next),
        .cur_rom_next  (cur_rom_next),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= '0;
            prev_rom_reg  <= '0;
            cur_rom_reg   <= '0;
        end else begin
            if (s_xfer) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                ctrl_reg      <= ctrl_next;
                prev_rom_reg  <= prev_rom_next;
                cur_rom_reg   <= cur_rom_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg.action         <= s_tuser;
            in_item_reg.presence       <= s_tdata[0];
            in_item_reg.true_bit       <= s_tdata[1];
            in_item_reg.complement_bit <= s_tdata[2];
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {{(M_TDATA_W-FOUND_W-1){1'b0}}, out_reg.found_rom, out_reg.write_bit};

endmodule

`default_nettype wire
